// File: rtl/core/sat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

  // Table geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned CAPS_W  = 3;
  localparam int unsigned SLEEP_W = 2;
  localparam int unsigned STAT_W  = 2;

  // Request commands
  typedef enum logic [1:0] {
    CMD_ASSOC  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POWER  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // Sleep states
  localparam logic [SLEEP_W-1:0] SLEEP_DEFAULT = 2'd0;
  localparam logic [SLEEP_W-1:0] SLEEP_AWAKE   = 2'd1;
  localparam logic [SLEEP_W-1:0] SLEEP_LOW     = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_DONE
  } state_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [SLEEP_W-1:0] sleep;
    logic [CAPS_W-1:0]  caps;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Update of the valid bits, from the sequencer
  typedef struct packed {
    logic             set;
    logic             clr;
    logic             clr_all;
    logic [IDX_W-1:0] idx;
  } vtab_op_t;

endpackage

`default_nettype wire

// File: rtl/core/sat_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sat_vtab.sv
`timescale 1ns / 1ps
`default_nettype none

module sat_vtab (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sat_pkg::vtab_op_t           op_i,
  output logic [sat_pkg::ENTRIES-1:0]      valid_o,
  output logic [sat_pkg::CNT_W-1:0]        count_o
);

  import sat_pkg::*;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // Apply set, clear or flush; the count follows each change
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (op_i.clr_all) begin
      valid_d = '0;
      count_d = '0;
    end else if (op_i.set) begin
      valid_d[op_i.idx] = 1'b1;
      count_d = count_q + CNT_W'(1);
    end else if (op_i.clr) begin
      valid_d[op_i.idx] = 1'b0;
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  assign valid_o = valid_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

// File: rtl/core/sat_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module sat_seq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request
  input  wire logic                           start_i,
  input  wire sat_pkg::cmd_e                  cmd_i,
  input  wire logic [sat_pkg::ADDR_W-1:0]     addr_i,
  input  wire logic [sat_pkg::CAPS_W-1:0]     caps_i,
  input  wire logic                           low_power_i,
  output logic                                busy_o,
  // result
  output logic                                done_o,
  output logic [sat_pkg::STAT_W-1:0]          status_o,
  output logic                                hit_o,
  output logic [sat_pkg::IDX_W-1:0]           idx_o,
  output logic [sat_pkg::SLEEP_W-1:0]         sleep_o,
  // valid bits
  input  wire logic [sat_pkg::ENTRIES-1:0]    valid_i,
  output sat_pkg::vtab_op_t                   vop_o,
  // entry RAM
  output logic                                ram_we_o,
  output logic [sat_pkg::IDX_W-1:0]           ram_waddr_o,
  output sat_pkg::entry_t                     ram_wdata_o,
  output logic                                ram_re_o,
  output logic [sat_pkg::IDX_W-1:0]           ram_raddr_o,
  input  wire sat_pkg::entry_t                ram_rdata_i
);

  import sat_pkg::*;

  localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(ENTRIES);

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [CAPS_W-1:0]  caps_q, caps_d;
  logic               lp_q, lp_d;
  logic [IDX_W:0]     rd_idx_q, rd_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   found_idx_q, found_idx_d;
  logic [SLEEP_W-1:0] found_sleep_q, found_sleep_d;
  logic [CAPS_W-1:0]  found_caps_q, found_caps_d;
  logic               free_q, free_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [STAT_W-1:0]  res_stat_q, res_stat_d;
  logic               res_hit_q, res_hit_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic [SLEEP_W-1:0] res_sleep_q, res_sleep_d;
  logic [SLEEP_W-1:0] new_sleep;

  assign new_sleep = lp_q ? SLEEP_LOW : SLEEP_AWAKE;

  // Next state, table scan and write-back
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    addr_d        = addr_q;
    caps_d        = caps_q;
    lp_d          = lp_q;
    rd_idx_d      = rd_idx_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    found_d       = found_q;
    found_idx_d   = found_idx_q;
    found_sleep_d = found_sleep_q;
    found_caps_d  = found_caps_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    res_stat_d    = res_stat_q;
    res_hit_d     = res_hit_q;
    res_idx_d     = res_idx_q;
    res_sleep_d   = res_sleep_q;
    vop_o         = '0;
    ram_we_o      = 1'b0;
    ram_waddr_o   = found_idx_q;
    ram_wdata_o   = '0;
    ram_re_o      = 1'b0;
    ram_raddr_o   = rd_idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d       = cmd_i;
          addr_d      = addr_i;
          caps_d      = caps_i;
          lp_d        = low_power_i;
          rd_idx_d    = '0;
          found_d     = 1'b0;
          free_d      = 1'b0;
          res_stat_d  = STAT_OK;
          res_hit_d   = 1'b0;
          res_idx_d   = '0;
          res_sleep_d = SLEEP_DEFAULT;
          if (cmd_i == CMD_CLEAR) begin
            vop_o.clr_all = 1'b1;
            state_d       = S_DONE;
          end else if (addr_i == '0) begin
            res_stat_d = STAT_ZERO;
            state_d    = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue one read per cycle
        if (rd_idx_q != SCAN_END) begin
          ram_re_o  = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + (IDX_W + 1)'(1);
        end
        // compare the entry read last cycle
        if (cmp_vld_q) begin
          if (valid_i[cmp_idx_q] && ram_rdata_i.addr == addr_q && !found_q) begin
            found_d       = 1'b1;
            found_idx_d   = cmp_idx_q;
            found_sleep_d = ram_rdata_i.sleep;
            found_caps_d  = ram_rdata_i.caps;
          end
          if (!valid_i[cmp_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (rd_idx_q == SCAN_END) begin
            state_d = S_ACT;
          end
        end
      end

      S_ACT: begin
        state_d = S_DONE;
        unique case (cmd_q)
          CMD_ASSOC: begin
            if (found_q) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = found_idx_q;
              ram_wdata_o = '{addr: addr_q, sleep: found_sleep_q, caps: caps_q};
              res_hit_d   = 1'b1;
              res_idx_d   = found_idx_q;
              res_sleep_d = found_sleep_q;
            end else if (free_q) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = free_idx_q;
              ram_wdata_o = '{addr: addr_q, sleep: SLEEP_DEFAULT, caps: caps_q};
              vop_o.set   = 1'b1;
              vop_o.idx   = free_idx_q;
              res_hit_d   = 1'b1;
              res_idx_d   = free_idx_q;
              res_sleep_d = SLEEP_DEFAULT;
            end else begin
              res_stat_d = STAT_FULL;
            end
          end
          CMD_REMOVE: begin
            if (found_q) begin
              vop_o.clr = 1'b1;
              vop_o.idx = found_idx_q;
              res_hit_d = 1'b1;
              res_idx_d = found_idx_q;
            end
          end
          CMD_POWER: begin
            if (found_q) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = found_idx_q;
              ram_wdata_o = '{addr: addr_q, sleep: new_sleep, caps: found_caps_q};
              res_hit_d   = 1'b1;
              res_idx_d   = found_idx_q;
              res_sleep_d = new_sleep;
            end
          end
          default: ;
        endcase
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // Request and scan payload
  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    addr_q        <= addr_d;
    caps_q        <= caps_d;
    lp_q          <= lp_d;
    rd_idx_q      <= rd_idx_d;
    cmp_idx_q     <= cmp_idx_d;
    found_q       <= found_d;
    found_idx_q   <= found_idx_d;
    found_sleep_q <= found_sleep_d;
    found_caps_q  <= found_caps_d;
    free_q        <= free_d;
    free_idx_q    <= free_idx_d;
    res_stat_q    <= res_stat_d;
    res_hit_q     <= res_hit_d;
    res_idx_q     <= res_idx_d;
    res_sleep_q   <= res_sleep_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_DONE);
  assign status_o = res_stat_q;
  assign hit_o    = res_hit_q;
  assign idx_o    = res_idx_q;
  assign sleep_o  = res_sleep_q;

endmodule

`default_nettype wire

// File: rtl/core/station_association_table.sv
// Channel  | Ports                                            | Dir | Handshake
// ---------+--------------------------------------------------+-----+-------------------
// request  | command_i station_addr_i roaming_flag_i          | in  | start_i, !busy_o
//          | sharing_flag_i vendor_flag_i low_power_i         |     |
// result   | status_o hit_o entry_index_o sleep_state_o       | out | done_o, one cycle
//          | active_count_o                                   |     |
//
// A clear or all-zero address request shows done_o in the cycle right after
// acceptance, and the next request is taken once the block is idle again.
// Any other request scans the entry RAM one entry per cycle through its
// single read port in S_SCAN, then in S_ACT writes back the entry or
// updates the valid bits as the command needs, and shows done_o in S_DONE;
// only after that, back in idle, can the block take the next request.
// busy_o stays high from acceptance until done_o has been shown.
// Reset clears the valid bits and the count at once; no clearing pass.
// The receiver cannot stall; results are presented for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module station_association_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [47:0] station_addr_i,
  input  wire logic        roaming_flag_i,
  input  wire logic        sharing_flag_i,
  input  wire logic        vendor_flag_i,
  input  wire logic        low_power_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             hit_o,
  output logic [3:0]       entry_index_o,
  output logic [1:0]       sleep_state_o,
  output logic [4:0]       active_count_o
);

  import sat_pkg::*;

  vtab_op_t           vop;
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   count;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;
  logic [IDX_W-1:0]   res_idx;

  // Sequencer: accept, scan, write back, report
  sat_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_e'(command_i)),
    .addr_i      (station_addr_i),
    .caps_i      ({vendor_flag_i, sharing_flag_i, roaming_flag_i}),
    .low_power_i (low_power_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .status_o    (status_o),
    .hit_o       (hit_o),
    .idx_o       (res_idx),
    .sleep_o     (sleep_state_o),
    .valid_i     (valid),
    .vop_o       (vop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Valid bits and active count
  sat_vtab u_vtab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (vop),
    .valid_o (valid),
    .count_o (count)
  );

  // Entry store: address, sleep state and capabilities
  sat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign entry_index_o  = 4'(res_idx);
  assign active_count_o = 5'(count);

  // Accepted request holds the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // Result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A hit always carries an ok status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (status_o == STAT_OK))
    else $error("hit reported with error status");

  // The active count never exceeds the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count <= CNT_W'(ENTRIES)))
    else $error("active count out of range");

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import sat_pkg::*;

  localparam int RANDOM_ITEMS   = 1500;
  localparam int PHASES         = 3;
  localparam int POOL_SIZE      = 20;
  localparam int GAP_MAX        = 24;
  localparam int TAIL_CYCLES    = 30;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [1:0] status;
    logic       hit;
    logic [3:0] index;
    logic [1:0] sleep;
    logic [4:0] count;
  } station_result_t;

  // Shadow of the station table; predicts one result per accepted request
  class station_scoreboard;
    bit              valid [ENTRIES];
    logic [47:0]     addr  [ENTRIES];
    logic [1:0]      sleep [ENTRIES];
    logic [2:0]      caps  [ENTRIES];
    station_result_t pending [$];
    int              errors;
    int              requests;
    int              results;
    int              hits;
    int              full_rejects;
    int              zero_rejects;
    int              clears;

    function int find_station(logic [47:0] a);
      foreach (valid[i]) begin
        if (valid[i] && addr[i] == a) return i;
      end
      return -1;
    endfunction

    function void note_request(cmd_e cmd, logic [47:0] a, logic [2:0] caps_in, logic dozing);
      station_result_t r;
      int              idx;
      int              n;
      r = '{STAT_OK, 1'b0, 4'd0, SLEEP_DEFAULT, 5'd0};
      idx = -1;
      n = 0;
      requests++;
      if (cmd == CMD_CLEAR) begin
        foreach (valid[i]) valid[i] = 1'b0;
        clears++;
      end else if (a == '0) begin
        r.status = STAT_ZERO;
        zero_rejects++;
      end else begin
        idx = find_station(a);
        case (cmd)
          CMD_ASSOC: begin
            // Take the lowest free entry on a miss
            if (idx < 0) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (!valid[i]) begin
                  idx      = i;
                  valid[i] = 1'b1;
                  addr[i]  = a;
                  sleep[i] = SLEEP_DEFAULT;
                  break;
                end
              end
            end
            if (idx < 0) begin
              r.status = STAT_FULL;
              full_rejects++;
            end else begin
              caps[idx] = caps_in;
              r.hit     = 1'b1;
              r.sleep   = sleep[idx];
            end
          end
          CMD_REMOVE: begin
            if (idx >= 0) begin
              valid[idx] = 1'b0;
              r.hit      = 1'b1;
            end
          end
          default: begin
            if (idx >= 0) begin
              sleep[idx] = dozing ? SLEEP_LOW : SLEEP_AWAKE;
              r.hit      = 1'b1;
              r.sleep    = sleep[idx];
            end
          end
        endcase
      end
      if (r.hit) begin
        r.index = 4'(idx);
        hits++;
      end
      foreach (valid[i]) n += valid[i];
      r.count = 5'(n);
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic hit, logic [3:0] index,
                               logic [1:0] sl, logic [4:0] count);
      station_result_t e;
      results++;
      if (pending.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (hit !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, hit);
        errors++;
      end
      if (index !== e.index) begin
        $error("entry_index: expected %0d, actual %0d", e.index, index);
        errors++;
      end
      if (sl !== e.sleep) begin
        $error("sleep_state: expected %0d, actual %0d", e.sleep, sl);
        errors++;
      end
      if (count !== e.count) begin
        $error("active_count: expected %0d, actual %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic [1:0]  command_i      = CMD_CLEAR;
  logic [47:0] station_addr_i = '0;
  logic        roaming_flag_i = 1'b0;
  logic        sharing_flag_i = 1'b0;
  logic        vendor_flag_i  = 1'b0;
  logic        low_power_i    = 1'b0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic        hit_o;
  logic [3:0]  entry_index_o;
  logic [1:0]  sleep_state_o;
  logic [4:0]  active_count_o;

  station_scoreboard sb = new();
  logic [47:0]       station_pool [POOL_SIZE];
  int                stall_cycles = 0;

  station_association_table DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .station_addr_i (station_addr_i),
    .roaming_flag_i (roaming_flag_i),
    .sharing_flag_i (sharing_flag_i),
    .vendor_flag_i  (vendor_flag_i),
    .low_power_i    (low_power_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .hit_o          (hit_o),
    .entry_index_o  (entry_index_o),
    .sleep_state_o  (sleep_state_o),
    .active_count_o (active_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [47:0] random_station();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Optionally idle, then hold the request until the block takes it
  task automatic drive_request(cmd_e cmd, logic [47:0] a, logic [2:0] caps, logic dozing,
                               int gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    command_i      <= cmd;
    station_addr_i <= a;
    roaming_flag_i <= caps[0];
    sharing_flag_i <= caps[1];
    vendor_flag_i  <= caps[2];
    low_power_i    <= dozing;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  // Check results, record accepted requests and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(status_o, hit_o, entry_index_o, sleep_state_o, active_count_o);
      end
      if (start_i && !busy_o) begin
        sb.note_request(cmd_e'(command_i), station_addr_i,
                        {vendor_flag_i, sharing_flag_i, roaming_flag_i}, low_power_i);
      end
      if (done_o || (start_i && !busy_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $error("no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int          gap_pct [PHASES];
    int          pick;
    cmd_e        cmd;
    logic [47:0] a;
    gap_pct = '{0, 54, 27};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: misses, zero addresses, clear with a zero address
    drive_request(CMD_REMOVE, 48'h0000_0000_00A1, 3'b000, 1'b0, 0);
    drive_request(CMD_POWER,  48'h0000_0000_00A1, 3'b000, 1'b1, 0);
    drive_request(CMD_ASSOC,  48'h0, 3'b111, 1'b1, 0);
    drive_request(CMD_REMOVE, 48'h0, 3'b000, 1'b0, 0);
    drive_request(CMD_POWER,  48'h0, 3'b000, 1'b1, 0);
    drive_request(CMD_CLEAR,  48'h0, 3'b111, 1'b1, 0);

    // New entry, reassociate, both power reports, remove hit
    drive_request(CMD_ASSOC,  48'hFFFF_FFFF_FFFF, 3'b111, 1'b1, 0);
    drive_request(CMD_ASSOC,  48'h0000_0000_0001, 3'b000, 1'b0, 0);
    drive_request(CMD_ASSOC,  48'hFFFF_FFFF_FFFF, 3'b010, 1'b0, 0);
    drive_request(CMD_POWER,  48'hFFFF_FFFF_FFFF, 3'b000, 1'b1, 0);
    drive_request(CMD_POWER,  48'h0000_0000_0001, 3'b101, 1'b0, 0);
    drive_request(CMD_REMOVE, 48'h0000_0000_0001, 3'b000, 1'b0, 0);

    // Fill every entry, then overflow, hit while full and clear
    for (int i = 0; i < ENTRIES - 1; i++) begin
      drive_request(CMD_ASSOC, 48'h0000_5A5A_0000 + 48'(i), 3'(i), 1'(i), 0);
    end
    drive_request(CMD_ASSOC, 48'h8000_0000_0000, 3'b111, 1'b0, 0);
    drive_request(CMD_ASSOC, 48'hFFFF_FFFF_FFFF, 3'b001, 1'b0, 0);
    drive_request(CMD_POWER, 48'h8000_0000_0000, 3'b000, 1'b1, 0);
    drive_request(CMD_CLEAR, 48'h0000_5A5A_0003, 3'b000, 1'b0, 0);

    // Random traffic over a small address pool so hits and overflow occur;
    // the receiver cannot stall, so only the sender gap varies by phase
    for (int p = 0; p < PHASES; p++) begin
      foreach (station_pool[i]) begin
        station_pool[i] = random_station();
        if (station_pool[i] == '0) station_pool[i] = 48'h1;
      end
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) cmd = CMD_ASSOC;
        else if (pick < 70) cmd = CMD_REMOVE;
        else if (pick < 97) cmd = CMD_POWER;
        else cmd = CMD_CLEAR;
        pick = $urandom_range(99);
        if (pick < 85) a = station_pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 95) a = random_station();
        else a = '0;
        drive_request(cmd, a, 3'($urandom), 1'($urandom), gap_pct[p]);
      end
    end
    start_i <= 1'b0;

    // Drain outstanding results, then allow for stray strobes
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d results over %0d sender gap settings.",
             sb.requests, sb.results, PHASES);
    $display("Hits %0d, table full %0d, zero address %0d, clears %0d.",
             sb.hits, sb.full_rejects, sb.zero_rejects, sb.clears);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: station_association_table.f
rtl/core/sat_pkg.sv
rtl/core/sat_ram.sv
rtl/core/sat_vtab.sv
rtl/core/sat_seq.sv
rtl/core/station_association_table.sv
verif/tb.sv
